// ----- rtl/hsmv_pkg.sv -----
// Shared types, constants and command/status structures of the histogram statistics core.
package hsmv_pkg;

  localparam int NUM_BINS_DEF    = 256;
  localparam int MAX_STATES_DEF  = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int SAMPLE_W  = 8;
  localparam int CFG_W     = 8;
  localparam int NSTATE_W  = 5;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W     = 10;
  localparam int LEN_W     = 9;
  localparam int Q_FRAC    = 16;
  localparam int DIGIT_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NSTATES = 2'd2;

  localparam logic [CFG_W-1:0]    LOW_RST     = 8'd0;
  localparam logic [CFG_W-1:0]    HIGH_RST    = 8'd255;
  localparam logic [NSTATE_W-1:0] NSTATES_RST = 5'd4;

  localparam logic [31:0] MEAN_EMPTY = 32'd1;
  localparam logic [31:0] VAR_SMALL  = 32'd7;
  localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;
  } hsmv_in_t;

  typedef struct packed {
    logic [3:0]  state_index;
    logic [31:0] state_count;
    logic [23:0] mean_q16;
    logic [31:0] variance_q16;
    logic        last_result;
  } hsmv_out_t;

  typedef struct packed {
    logic [CFG_W-1:0]    low;
    logic [CFG_W-1:0]    high;
    logic [NSTATE_W-1:0] num_states;
  } hsmv_cfg_t;

  typedef enum logic [1:0] {
    DIV_SZ   = 2'd0,
    DIV_MEAN = 2'd1,
    DIV_VAR  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     clr_wr;
    logic     smp_rd;
    logic     smp_wr;
    logic     div_start;
    div_sel_t div_sel;
    logic     sz_take;
    logic     grp_init;
    logic     grp_setup;
    logic     grp_next;
    logic     bin_rd;
    logic     p1_mul;
    logic     p1_acc;
    logic     mean_empty;
    logic     mean_take;
    logic     var_small;
    logic     var_take;
    logic     cur_reset;
    logic     p2_ad;
    logic     p2_sq;
    logic     p2_mul;
    logic     p2_add;
    logic     bin_next;
  } hsmv_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic smp_last;
    logic div_done;
    logic bin_ok;
    logic n_zero;
    logic n_le1;
    logic cnt_zero;
    logic grp_last;
  } hsmv_status_t;

endpackage

// ----- rtl/hsmv_div.sv -----
// Restoring divider, one quotient bit per cycle, quotient saturated at 32 bits.
module hsmv_div #(
  parameter int DW = 96,
  parameter int NW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] x,
  input  logic [NW-1:0] d,
  output logic [31:0]   q,
  output logic          done
);
  import hsmv_pkg::*;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] d_r, d_nxt;
  logic [31:0]   lo_r, lo_nxt;
  logic [31:0]   q_r, q_nxt;
  logic [NW:0]   rem2;
  logic [DW-33:0] hi;

  assign hi   = x[DW-1:32];
  assign rem2 = {rem_r, lo_r[31]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    if (start) begin
      d_nxt = d;
      if (hi >= (DW-32)'(d)) begin
        q_nxt    = SAT32;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = NW'(hi);
        lo_nxt   = x[31:0];
        cnt_nxt  = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (rem2 >= {1'b0, d_r}) begin
        rem_nxt = NW'(rem2 - {1'b0, d_r});
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = NW'(rem2);
        q_nxt   = {q_r[30:0], 1'b0};
      end
      lo_nxt  = {lo_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
  end

  assign q    = q_r;
  assign done = done_r;

endmodule

// ----- rtl/hsmv_dp.sv -----
// Datapath: histogram memory, group accumulators, multipliers and the shared divider.
module hsmv_dp #(
  parameter int NUM_BINS    = 256,
  parameter int MAX_STATES  = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hsmv_pkg::hsmv_cfg_t     cfg,
  input  hsmv_pkg::hsmv_in_t      in_data,
  input  hsmv_pkg::hsmv_cmd_t     cmd,
  output hsmv_pkg::hsmv_status_t  st,
  output hsmv_pkg::hsmv_out_t     out_data
);
  import hsmv_pkg::*;

  localparam int AW   = $clog2(NUM_BINS);
  localparam int VW   = $clog2(NUM_BINS);
  localparam int CW   = COUNT_WIDTH;
  localparam int NW   = CW + VW;
  localparam int SW   = NW + VW;
  localparam int PW   = CW + VW;
  localparam int ADW  = VW + Q_FRAC;
  localparam int AD2W = 2 * ADW;
  localparam int ACCW = AD2W + NW;
  localparam int DW   = NW + 2 * VW + 48;
  localparam int TW   = $clog2(MAX_STATES + 1);

  logic [CW-1:0] bin_mem_r [NUM_BINS];
  logic [CW-1:0] rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [CW-1:0] mem_wdata;

  logic [AW-1:0]       clr_r, clr_nxt;
  logic [SAMPLE_W-1:0] samp_r;
  logic                last_r;
  logic                samp_ok;

  logic [LEN_W-1:0] sz_r;
  logic [TW-1:0]    g_r;
  logic [POS_W-1:0] first_r, lastv_r, v_r;
  logic             gval_r;
  logic [NW-1:0]    n_r;
  logic [SW-1:0]    sum_r;
  logic [PW-1:0]    prod_r;
  logic [CW-1:0]    cnt_r;
  logic [31:0]      mean_r, var_r;
  logic [ADW-1:0]   ad_r;
  logic [ACCW-1:0]  ad2sh_r, pp_r, acc_r;

  logic [TW-1:0]    term;
  logic             rng_ok;
  logic [LEN_W-1:0] len;
  logic             grp_last, ne;
  logic [PW-1:0]    p1;
  logic [AD2W-1:0]  sq;
  logic [32:0]      vx, mx;
  logic [DW-1:0]    div_x;
  logic [NW-1:0]    div_d;
  logic [31:0]      div_q;
  logic             div_done;

  always_comb begin
    if (cfg.num_states == '0) begin
      term = TW'(1);
    end else if (32'(cfg.num_states) > MAX_STATES) begin
      term = TW'(MAX_STATES);
    end else begin
      term = TW'(cfg.num_states);
    end
  end

  assign rng_ok   = cfg.high >= cfg.low;
  assign len      = rng_ok ? (LEN_W'(cfg.high) - LEN_W'(cfg.low) + LEN_W'(1)) : '0;
  assign grp_last = (g_r == term - TW'(1));
  assign ne       = rng_ok && (sz_r != '0);
  assign samp_ok  = 32'(samp_r) < NUM_BINS;

  assign mem_raddr = cmd.smp_rd ? AW'(32'(in_data.sample)) : AW'(32'(v_r));
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = '0;
    if (cmd.clr_wr) begin
      mem_we = 1'b1;
    end else if (cmd.smp_wr && samp_ok) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(32'(samp_r));
      mem_wdata = (rdata_r == '1) ? rdata_r : rdata_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem_r[mem_waddr] <= mem_wdata;
    end
    if (cmd.smp_rd || cmd.bin_rd) begin
      rdata_r <= bin_mem_r[mem_raddr];
    end
  end

  assign clr_nxt = (clr_r == AW'(NUM_BINS - 1)) ? '0 : clr_r + AW'(1);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_r <= clr_nxt;
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      DIV_SZ: begin
        div_x = DW'(len);
        div_d = NW'(term);
      end
      DIV_MEAN: begin
        div_x = DW'(sum_r) << Q_FRAC;
        div_d = n_r;
      end
      DIV_VAR: begin
        div_x = DW'(acc_r >> Q_FRAC);
        div_d = n_r - NW'(1);
      end
      default: begin
        div_x = '0;
        div_d = NW'(1);
      end
    endcase
  end

  hsmv_div #(
    .DW(DW),
    .NW(NW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .x    (div_x),
    .d    (div_d),
    .q    (div_q),
    .done (div_done)
  );

  assign p1 = PW'(rdata_r) * PW'(VW'(v_r));
  assign sq = AD2W'(ad_r) * AD2W'(ad_r);
  assign vx = 33'(v_r) << Q_FRAC;
  assign mx = 33'(mean_r);

  always_ff @(posedge clk) begin
    if (cmd.smp_rd) begin
      samp_r <= in_data.sample;
      last_r <= in_data.last_sample;
    end
    if (cmd.sz_take) begin
      sz_r <= LEN_W'(div_q);
    end
    if (cmd.grp_init) begin
      g_r     <= '0;
      first_r <= POS_W'(cfg.low);
    end else if (cmd.grp_next) begin
      g_r     <= g_r + TW'(1);
      first_r <= first_r + POS_W'(sz_r);
    end
    if (cmd.grp_setup) begin
      v_r   <= first_r;
      n_r   <= '0;
      sum_r <= '0;
      acc_r <= '0;
      if (grp_last) begin
        lastv_r <= POS_W'(cfg.high);
        gval_r  <= rng_ok;
      end else begin
        lastv_r <= first_r + POS_W'(sz_r) - (ne ? POS_W'(1) : '0);
        gval_r  <= ne;
      end
    end else if (cmd.cur_reset) begin
      v_r   <= first_r;
      acc_r <= '0;
    end else begin
      if (cmd.p1_acc) begin
        n_r   <= n_r + NW'(cnt_r);
        sum_r <= sum_r + SW'(prod_r);
      end
      if (cmd.p2_add) begin
        acc_r <= acc_r + pp_r;
      end
      if (cmd.p1_acc || cmd.bin_next) begin
        v_r <= v_r + POS_W'(1);
      end
    end
    if (cmd.p1_mul) begin
      prod_r <= p1;
      cnt_r  <= rdata_r;
    end else if (cmd.p2_ad) begin
      cnt_r <= rdata_r;
      ad_r  <= ADW'((vx >= mx) ? (vx - mx) : (mx - vx));
    end else if (cmd.p2_mul) begin
      pp_r    <= ad2sh_r * ACCW'(cnt_r[DIGIT_W-1:0]);
      cnt_r   <= cnt_r >> DIGIT_W;
      ad2sh_r <= ad2sh_r << DIGIT_W;
    end
    if (cmd.p2_sq) begin
      ad2sh_r <= ACCW'(sq);
    end
    if (cmd.mean_empty) begin
      mean_r <= MEAN_EMPTY;
    end else if (cmd.mean_take) begin
      mean_r <= div_q;
    end
    if (cmd.var_small) begin
      var_r <= VAR_SMALL;
    end else if (cmd.var_take) begin
      var_r <= div_q;
    end
  end

  assign st.clr_done = (clr_r == AW'(NUM_BINS - 1));
  assign st.smp_last = last_r;
  assign st.div_done = div_done;
  assign st.bin_ok   = gval_r && (v_r <= lastv_r) && (32'(v_r) < NUM_BINS);
  assign st.n_zero   = (n_r == '0);
  assign st.n_le1    = (n_r <= NW'(1));
  assign st.cnt_zero = (cnt_r == '0);
  assign st.grp_last = grp_last;

  assign out_data.state_index  = 4'(g_r);
  assign out_data.state_count  = (64'(n_r) > 64'(SAT32)) ? SAT32 : 32'(n_r);
  assign out_data.mean_q16     = mean_r[23:0];
  assign out_data.variance_q16 = var_r;
  assign out_data.last_result  = grp_last;

endmodule

// ----- rtl/hsmv_ctrl.sv -----
// Controller state machine sequencing sample updates, group passes and the clearing sweep.
module hsmv_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  hsmv_pkg::hsmv_status_t st,
  output hsmv_pkg::hsmv_cmd_t    cmd
);
  import hsmv_pkg::*;

  typedef enum logic [18:0] {
    S_CLEAR = 19'h00001,
    S_IDLE  = 19'h00002,
    S_UPD   = 19'h00004,
    S_SZ    = 19'h00008,
    S_SZW   = 19'h00010,
    S_GRP   = 19'h00020,
    S_P1    = 19'h00040,
    S_P1M   = 19'h00080,
    S_P1A   = 19'h00100,
    S_MEAN  = 19'h00200,
    S_MEANW = 19'h00400,
    S_P2    = 19'h00800,
    S_P2D   = 19'h01000,
    S_P2S   = 19'h02000,
    S_P2M   = 19'h04000,
    S_P2A   = 19'h08000,
    S_VAR   = 19'h10000,
    S_VARW  = 19'h20000,
    S_OUT   = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = DIV_SZ;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.smp_rd = 1'b1;
          state_nxt  = S_UPD;
        end
      end
      S_UPD: begin
        cmd.smp_wr = 1'b1;
        state_nxt  = st.smp_last ? S_SZ : S_IDLE;
      end
      S_SZ: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SZ;
        state_nxt     = S_SZW;
      end
      S_SZW: begin
        if (st.div_done) begin
          cmd.sz_take  = 1'b1;
          cmd.grp_init = 1'b1;
          state_nxt    = S_GRP;
        end
      end
      S_GRP: begin
        cmd.grp_setup = 1'b1;
        state_nxt     = S_P1;
      end
      S_P1: begin
        if (st.bin_ok) begin
          cmd.bin_rd = 1'b1;
          state_nxt  = S_P1M;
        end else begin
          state_nxt = S_MEAN;
        end
      end
      S_P1M: begin
        cmd.p1_mul = 1'b1;
        state_nxt  = S_P1A;
      end
      S_P1A: begin
        cmd.p1_acc = 1'b1;
        state_nxt  = S_P1;
      end
      S_MEAN: begin
        if (st.n_zero) begin
          cmd.mean_empty = 1'b1;
          cmd.var_small  = 1'b1;
          state_nxt      = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_MEAN;
          state_nxt     = S_MEANW;
        end
      end
      S_MEANW: begin
        if (st.div_done) begin
          cmd.mean_take = 1'b1;
          if (st.n_le1) begin
            cmd.var_small = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            cmd.cur_reset = 1'b1;
            state_nxt     = S_P2;
          end
        end
      end
      S_P2: begin
        if (st.bin_ok) begin
          cmd.bin_rd = 1'b1;
          state_nxt  = S_P2D;
        end else begin
          state_nxt = S_VAR;
        end
      end
      S_P2D: begin
        cmd.p2_ad = 1'b1;
        state_nxt = S_P2S;
      end
      S_P2S: begin
        if (st.cnt_zero) begin
          cmd.bin_next = 1'b1;
          state_nxt    = S_P2;
        end else begin
          cmd.p2_sq = 1'b1;
          state_nxt = S_P2M;
        end
      end
      S_P2M: begin
        cmd.p2_mul = 1'b1;
        state_nxt  = S_P2A;
      end
      S_P2A: begin
        cmd.p2_add = 1'b1;
        if (st.cnt_zero) begin
          cmd.bin_next = 1'b1;
          state_nxt    = S_P2;
        end else begin
          state_nxt = S_P2M;
        end
      end
      S_VAR: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_VAR;
        state_nxt     = S_VARW;
      end
      S_VARW: begin
        cmd.div_sel = DIV_VAR;
        if (st.div_done) begin
          cmd.var_take = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (st.grp_last) begin
            state_nxt = S_CLEAR;
          end else begin
            cmd.grp_next = 1'b1;
            state_nxt    = S_GRP;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/histogram_state_mean_variance_core.sv -----
// Top level of the histogram statistics core: configuration registers and block wiring.
//
//   port group | direction | handshake            | payload
//   in_        | input     | in_valid / in_ready   | sample, last_sample
//   out_       | output    | out_valid / out_ready | state_index, state_count, mean, variance
//   cfg_       | input     | cfg_we                | cfg_index, cfg_wdata
//
// Each sample request is a memory read followed by a saturating write back.
// A final sample starts emission: a division for the group size, then per group a pass
// over its bins for the count and sum, a division for the mean and, with more than one
// sample in the group, a second pass over the bins and a division for the variance, all
// on the one memory port. After reset and after the final result a clearing pass over
// all NUM_BINS bins runs with in_ready low. A stalled result request holds the block;
// configuration is always taken.
module histogram_state_mean_variance_core #(
  parameter int NUM_BINS    = hsmv_pkg::NUM_BINS_DEF,
  parameter int MAX_STATES  = hsmv_pkg::MAX_STATES_DEF,
  parameter int COUNT_WIDTH = hsmv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  hsmv_pkg::hsmv_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output hsmv_pkg::hsmv_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [hsmv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hsmv_pkg::CFG_W-1:0]          cfg_wdata
);
  import hsmv_pkg::*;

  logic [CFG_W-1:0]    low_r, high_r;
  logic [NSTATE_W-1:0] nst_r;
  hsmv_cfg_t           cfg;
  hsmv_cmd_t           cmd;
  hsmv_status_t        st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= LOW_RST;
      high_r <= HIGH_RST;
      nst_r  <= NSTATES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW:     low_r  <= cfg_wdata;
        CFG_HIGH:    high_r <= cfg_wdata;
        CFG_NSTATES: nst_r  <= cfg_wdata[NSTATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.low        = low_r;
  assign cfg.high       = high_r;
  assign cfg.num_states = nst_r;

  hsmv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .st       (st),
    .cmd      (cmd)
  );

  hsmv_dp #(
    .NUM_BINS   (NUM_BINS),
    .MAX_STATES (MAX_STATES),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_data (in_data),
    .cmd     (cmd),
    .st      (st),
    .out_data(out_data)
  );

endmodule
